[hdl/cia_pkg.sv]
// Package: op codes, error codes and shared unit control types for the checked integer ALU.
`default_nettype none
package cia_pkg;
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_NEG = 4'd3;
	localparam logic [3:0] OP_ABS = 4'd4;
	localparam logic [3:0] OP_DIV = 4'd5;
	localparam logic [3:0] OP_MOD = 4'd6;
	localparam logic [3:0] OP_POW = 4'd7;
	localparam logic [3:0] OP_MAX = 4'd8;
	localparam logic [3:0] OP_MIN = 4'd9;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_OVF    = 2'd1;
	localparam logic [1:0] ERR_ZDIV   = 2'd2;
	localparam logic [1:0] ERR_NEGEXP = 2'd3;

	typedef enum logic {
		MODE_MUL = 1'b0,
		MODE_DIV = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} unit_ctrl_t;
endpackage
`default_nettype wire

[hdl/cia_req_if.sv]
// Request channel: operation and two signed operands.
`default_nettype none
interface cia_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, output op, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface
`default_nettype wire

[hdl/cia_rsp_if.sv]
// Result channel: signed value and error code.
`default_nettype none
interface cia_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         error_code;

	modport source (output valid, output value, output error_code, input ready);
	modport sink   (input valid, input value, input error_code, output ready);
endinterface
`default_nettype wire

[hdl/cia_unit.sv]
// Shared bit-serial unit: unsigned shift-add multiply or restoring divide, one bit per cycle.
`default_nettype none
module cia_unit #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cia_pkg::unit_ctrl_t ctrl,
	input  wire logic [W-1:0]        opa,   // multiplicand or divisor
	input  wire logic [W-1:0]        opb,   // multiplier or dividend
	output logic                     done,
	output logic [W-1:0]             hi,    // product high or remainder
	output logic [W-1:0]             lo     // product low or quotient
);
	import cia_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	unit_mode_t       mode_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     hi_q;
	logic [W-1:0]     lo_q;

	logic [W:0]       msum;
	logic [W:0]       dtry;
	logic [W:0]       ddif;

	// one step of either algorithm
	always_comb begin
		msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x_q} : '0);
		dtry = {hi_q, lo_q[W-1]};
		ddif = dtry - {1'b0, x_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.mode;
			x_q    <= opa;
			hi_q   <= '0;
			lo_q   <= opb;
		end else if (busy_q) begin
			if (mode_q == MODE_MUL) begin
				hi_q <= msum[W:1];
				lo_q <= {msum[0], lo_q[W-1:1]};
			end else begin
				hi_q <= ddif[W] ? dtry[W-1:0] : ddif[W-1:0];
				lo_q <= {lo_q[W-2:0], ~ddif[W]};
			end
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;
endmodule
`default_nettype wire

[hdl/checked_integer_alu.sv]
// Top level: checked signed integer ALU with a sequencer around one shared multiply/divide unit.
// Add, sub, neg, abs, max, min and the special cases are resolved in the dispatch state.
// Multiply and divide/modulo run in the shared unit, one bit per cycle.
// Power runs left-to-right square-and-multiply, exponent limited to clog2(WORD_BITS) bits.
// One item at a time: a request is taken only in idle, re-entered when the result is loaded.
// arst_n clears sequencer and output valid; datapath is not reset.
`default_nettype none
module checked_integer_alu #(
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cia_req_if.sink   operands,
	cia_rsp_if.source result
);
	import cia_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int KB = $clog2(W);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONEV = W'(1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DISP = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_PSQ  = 7'b0010000,
		S_PML  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	logic [3:0]     op_q;
	logic [W-1:0]   a_q, b_q, acc_q, acc_d, rv_q, rv_d;
	logic [1:0]     re_q, re_d;
	logic [KB-1:0]  k_q, k_d;
	logic           ovalid_q;
	logic [31:0]    value_q;
	logic [1:0]     err_q;

	logic [W-1:0]   in_a, in_b;
	logic [31:0]    rv32;
	unit_ctrl_t     u_ctrl;
	logic [W-1:0]   u_x, u_y, u_hi, u_lo;
	logic           u_done;

	logic           accept, load_out;
	logic           sa, sb, mneg, u_over;
	logic [W-1:0]   ma, mb, lim;
	logic [W:0]     add_s, sub_s;

	// operand sign extension and result width adaptation
	generate
		if (W <= 32) begin : g_narrow
			assign in_a = operands.operand_a[W-1:0];
			assign in_b = operands.operand_b[W-1:0];
		end else begin : g_wide_in
			assign in_a = {{(W-32){operands.operand_a[31]}}, operands.operand_a};
			assign in_b = {{(W-32){operands.operand_b[31]}}, operands.operand_b};
		end
		if (W < 32) begin : g_ext_out
			assign rv32 = {{(32-W){rv_q[W-1]}}, rv_q};
		end else begin : g_cut_out
			assign rv32 = rv_q[31:0];
		end
	endgenerate

	cia_unit #(.W(W)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (u_ctrl),
		.opa    (u_x),
		.opb    (u_y),
		.done   (u_done),
		.hi     (u_hi),
		.lo     (u_lo)
	);

	assign accept   = operands.valid && operands.ready;
	assign operands.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!ovalid_q || result.ready);

	// operand helpers and product range check
	always_comb begin
		sa     = a_q[W-1];
		sb     = b_q[W-1];
		ma     = sa ? -a_q : a_q;
		mb     = sb ? -b_q : b_q;
		add_s  = {sa, a_q} + {sb, b_q};
		sub_s  = {sa, a_q} - {sb, b_q};
		mneg   = (op_q == OP_POW) ? (sa & b_q[0]) : (sa ^ sb);
		lim    = mneg ? MINV : MAXV;
		u_over = (|u_hi) || (u_lo > lim);
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		acc_d        = acc_q;
		k_d          = k_q;
		rv_d         = rv_q;
		re_d         = re_q;
		u_ctrl.start = 1'b0;
		u_ctrl.mode  = MODE_MUL;
		u_x          = acc_q;
		u_y          = acc_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DISP;
			end
			S_DISP: begin
				state_d = S_DONE;
				rv_d    = '0;
				re_d    = ERR_NONE;
				case (op_q)
					OP_ADD: begin
						if (add_s[W] ^ add_s[W-1]) re_d = ERR_OVF;
						else rv_d = add_s[W-1:0];
					end
					OP_SUB: begin
						if (sub_s[W] ^ sub_s[W-1]) re_d = ERR_OVF;
						else rv_d = sub_s[W-1:0];
					end
					OP_NEG, OP_ABS: begin
						if (a_q == MINV) re_d = ERR_OVF;
						else if (op_q == OP_NEG) rv_d = -a_q;
						else rv_d = ma;
					end
					OP_MAX: rv_d = ($signed(a_q) > $signed(b_q)) ? a_q : b_q;
					OP_MIN: rv_d = ($signed(a_q) < $signed(b_q)) ? a_q : b_q;
					OP_MUL: begin
						u_ctrl.start = 1'b1;
						u_x          = ma;
						u_y          = mb;
						state_d      = S_MUL;
					end
					OP_DIV, OP_MOD: begin
						if (b_q == '0) re_d = ERR_ZDIV;
						else if (b_q == '1) begin
							if (op_q == OP_DIV) begin
								if (a_q == MINV) re_d = ERR_OVF;
								else rv_d = -a_q;
							end
						end else begin
							u_ctrl.start = 1'b1;
							u_ctrl.mode  = MODE_DIV;
							u_x          = mb;
							u_y          = ma;
							state_d      = S_DIV;
						end
					end
					OP_POW: begin
						if (sb) re_d = ERR_NEGEXP;
						else if (b_q == '0) rv_d = ONEV;
						else if (a_q == '0 || a_q == ONEV) rv_d = a_q;
						else if (a_q == '1) rv_d = b_q[0] ? '1 : ONEV;
						else if (b_q > W'(W - 1)) re_d = ERR_OVF;
						else begin
							// |a| >= 2 and a small exponent: square-and-multiply on magnitudes
							acc_d        = ONEV;
							k_d          = KB'(KB - 1);
							u_ctrl.start = 1'b1;
							u_x          = ONEV;
							u_y          = ONEV;
							state_d      = S_PSQ;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				if (u_done) begin
					state_d = S_DONE;
					if (u_over) begin
						re_d = ERR_OVF;
						rv_d = '0;
					end else begin
						re_d = ERR_NONE;
						rv_d = mneg ? -u_lo : u_lo;
					end
				end
			end
			S_DIV: begin
				if (u_done) begin
					// Euclidean correction: negative dividend with nonzero remainder
					state_d = S_DONE;
					re_d    = ERR_NONE;
					if (sa && (u_hi != '0)) begin
						if (op_q == OP_MOD) rv_d = mb - u_hi;
						else rv_d = sb ? (u_lo + ONEV) : ~u_lo;
					end else begin
						if (op_q == OP_MOD) rv_d = u_hi;
						else rv_d = (sa ^ sb) ? -u_lo : u_lo;
					end
				end
			end
			S_PSQ, S_PML: begin
				if (u_done) begin
					acc_d = u_lo;
					if (u_over) begin
						re_d    = ERR_OVF;
						rv_d    = '0;
						state_d = S_DONE;
					end else if (state_q == S_PSQ && b_q[k_q]) begin
						u_ctrl.start = 1'b1;
						u_x          = u_lo;
						u_y          = ma;
						state_d      = S_PML;
					end else if (k_q == '0) begin
						re_d    = ERR_NONE;
						rv_d    = mneg ? -u_lo : u_lo;
						state_d = S_DONE;
					end else begin
						k_d          = k_q - 1'b1;
						u_ctrl.start = 1'b1;
						u_x          = u_lo;
						u_y          = u_lo;
						state_d      = S_PSQ;
					end
				end
			end
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) ovalid_q <= 1'b1;
			else if (result.ready) ovalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operands.op;
			a_q  <= in_a;
			b_q  <= in_b;
		end
		acc_q <= acc_d;
		k_q   <= k_d;
		rv_q  <= rv_d;
		re_q  <= re_d;
		if (load_out) begin
			value_q <= rv32;
			err_q   <= re_q;
		end
	end

	assign result.valid      = ovalid_q;
	assign result.value      = value_q;
	assign result.error_code = err_q;

	// an error always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && (re_q != ERR_NONE) |-> (rv_q == '0))
		else $error("error result with nonzero value");

	// zero divide comes only from divide or modulo
	a_zdiv_op: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && (re_q == ERR_ZDIV) |-> (op_q == OP_DIV || op_q == OP_MOD))
		else $error("zero divide on wrong op");

	// shared unit finishes only while the sequencer waits on it
	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == S_MUL || state_q == S_DIV || state_q == S_PSQ
			|| state_q == S_PML))
		else $error("unit done outside a wait state");
endmodule
`default_nettype wire

[verif/tb_checked_integer_alu.sv]
// Testbench for the checked integer ALU: directed table, random requests, self-checking predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_checked_integer_alu;
	import cia_pkg::*;

	localparam int N_RANDOM = 450;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               has_exp;
		logic signed [31:0] exp_value;
		logic [1:0]         exp_err;
	} row_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         err;
	} outcome_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   idle_cycles = 0;
	bit   stim_done;
	outcome_t pending_q[$];

	cia_req_if operands();
	cia_rsp_if result();

	checked_integer_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands.sink),
		.result(result.source)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Checked product at 32 bits; returns 1 on overflow
	function automatic bit mul_ovf(input longint x, input longint y, output longint p);
		p = x * y;
		return (p > 64'sd2147483647) || (p < -64'sd2147483648);
	endfunction

	// Expected outcome of one request
	function automatic outcome_t alu_outcome(input logic [3:0] op,
			input logic signed [31:0] a32, input logic signed [31:0] b32);
		outcome_t o;
		longint a, b, r, q, acc;
		bit ovf;
		a = a32;
		b = b32;
		r = 0;
		o.err = ERR_NONE;
		case (op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = a * b;
			OP_NEG: r = -a;
			OP_ABS: r = (a < 0) ? -a : a;
			OP_DIV, OP_MOD: begin
				if (b == 0) o.err = ERR_ZDIV;
				else begin
					q = a / b;
					r = a % b;
					if (r < 0) begin
						if (b > 0) begin q -= 1; r += b; end
						else begin q += 1; r -= b; end
					end
					if (op == OP_DIV) r = q;
				end
			end
			OP_POW: begin
				if (b < 0) o.err = ERR_NEGEXP;
				else if (b == 0) r = 1;
				else if (a == 0 || a == 1) r = a;
				else if (a == -1) r = b[0] ? -1 : 1;
				else begin
					acc = a;
					ovf = 0;
					for (longint i = 1; i < b && !ovf; i++) ovf = mul_ovf(acc, a, acc);
					if (ovf) o.err = ERR_OVF;
					r = acc;
				end
			end
			OP_MAX: r = (a > b) ? a : b;
			OP_MIN: r = (a < b) ? a : b;
			default: r = 0;
		endcase
		if (o.err == ERR_NONE && (r > 64'sd2147483647 || r < -64'sd2147483648)) o.err = ERR_OVF;
		o.value = (o.err == ERR_NONE) ? r[31:0] : 32'sd0;
		return o;
	endfunction

	// Directed table
	localparam logic signed [31:0] IMAX = 32'sh7fffffff;
	localparam logic signed [31:0] IMIN = 32'sh80000000;
	row_t dir_rows[] = '{
		'{OP_ADD, IMAX, 32'sd1, 1'b1, 32'sd0, ERR_OVF},
		'{OP_ADD, IMIN, -32'sd1, 1'b1, 32'sd0, ERR_OVF},
		'{OP_SUB, IMIN, 32'sd1, 1'b1, 32'sd0, ERR_OVF},
		'{OP_SUB, 32'sd0, IMIN, 1'b1, 32'sd0, ERR_OVF},
		'{OP_MUL, IMIN, -32'sd1, 1'b1, 32'sd0, ERR_OVF},
		'{OP_MUL, 32'sd65536, 32'sd32768, 1'b0, 32'sd0, ERR_NONE},
		'{OP_MUL, -32'sd65536, 32'sd32768, 1'b1, IMIN, ERR_NONE},
		'{OP_NEG, IMIN, 32'sd5, 1'b1, 32'sd0, ERR_OVF},
		'{OP_NEG, IMAX, IMIN, 1'b1, -IMAX, ERR_NONE},
		'{OP_ABS, IMIN, 32'sd0, 1'b1, 32'sd0, ERR_OVF},
		'{OP_ABS, -32'sd7, IMAX, 1'b1, 32'sd7, ERR_NONE},
		'{OP_DIV, 32'sd5, 32'sd0, 1'b1, 32'sd0, ERR_ZDIV},
		'{OP_MOD, IMIN, 32'sd0, 1'b1, 32'sd0, ERR_ZDIV},
		'{OP_DIV, IMIN, -32'sd1, 1'b1, 32'sd0, ERR_OVF},
		'{OP_MOD, IMIN, -32'sd1, 1'b1, 32'sd0, ERR_NONE},
		'{OP_DIV, -32'sd7, 32'sd2, 1'b0, 32'sd0, ERR_NONE},
		'{OP_MOD, -32'sd7, -32'sd2, 1'b0, 32'sd0, ERR_NONE},
		'{OP_POW, 32'sd3, -32'sd1, 1'b1, 32'sd0, ERR_NEGEXP},
		'{OP_POW, 32'sd0, 32'sd0, 1'b1, 32'sd1, ERR_NONE},
		'{OP_POW, 32'sd0, IMAX, 1'b1, 32'sd0, ERR_NONE},
		'{OP_POW, -32'sd1, IMAX, 1'b1, -32'sd1, ERR_NONE},
		'{OP_POW, -32'sd2, 32'sd31, 1'b1, IMIN, ERR_NONE},
		'{OP_POW, 32'sd2, 32'sd31, 1'b1, 32'sd0, ERR_OVF},
		'{OP_MAX, IMIN, IMAX, 1'b1, IMAX, ERR_NONE},
		'{OP_MIN, IMIN, IMAX, 1'b1, IMIN, ERR_NONE},
		'{4'd15, IMAX, IMIN, 1'b1, 32'sd0, ERR_NONE}
	};

	// Drive one request at the falling edge and hold it until accepted
	task automatic send_request(input logic [3:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b, input bit hold_valid);
		operands.valid <= 1'b1;
		operands.op <= op;
		operands.operand_a <= a;
		operands.operand_b <= b;
		do @(posedge clk); while (!operands.ready);
		pending_q.push_back(alu_outcome(op, a, b));
		@(negedge clk);
		if (!hold_valid) operands.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return IMAX - $urandom_range(0, 2);
			1: return IMIN + $urandom_range(0, 2);
			2: return $signed($urandom_range(0, 8)) - 32'sd4;
			3: return $signed($urandom_range(0, 200)) - 32'sd100;
			4: return $signed($urandom_range(0, 131072)) - 32'sd65536;
			default: return $signed($urandom());
		endcase
	endfunction

	// Stimulus
	initial begin
		outcome_t chk;
		int burst;
		logic [3:0] rop;
		logic signed [31:0] ra, rb;
		fail_count = 0;
		stim_done = 0;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.op = '0;
		operands.operand_a = '0;
		operands.operand_b = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// each next request is driven in the same step, so valid is never dropped here
		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp) begin
				chk = alu_outcome(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
				if (chk.value !== dir_rows[i].exp_value || chk.err !== dir_rows[i].exp_err)
					report_mismatch($sformatf("table row %0d disagrees with predictor", i));
			end
			send_request(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, 1'b1);
		end
		// Random requests in bursts, with valid dropped between bursts
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				rop = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(10, 15))
					: 4'($urandom_range(0, 9));
				ra = rand_operand();
				rb = rand_operand();
				if (rop == OP_POW && $urandom_range(0, 2) != 0) rb = $urandom_range(0, 40);
				send_request(rop, ra, rb, 1'b1);
			end
			operands.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
		stim_done = 1;
	end

	// Receiver stall pattern and checking
	initial begin
		int phase;
		phase = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if ((phase / 200) % 3 == 2) result.ready <= 1'b1;
			else result.ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && result.valid && result.ready) begin
			if (pending_q.size() == 0) report_mismatch("result with nothing expected");
			else begin
				e = pending_q.pop_front();
				if (result.value !== e.value)
					report_mismatch($sformatf("value %0d expected %0d", result.value, e.value));
				if (result.error_code !== e.err)
					report_mismatch($sformatf("error_code %0d expected %0d",
						result.error_code, e.err));
			end
		end
	end

	// Watchdog and end of run
	always @(posedge clk) begin
		if ((operands.valid && operands.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done && pending_q.size() == 0 || idle_cycles >= IDLE_LIMIT);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			repeat (500) @(posedge clk);
			if (fail_count == 0) $display("Test completed successfully");
			else $display("Test completed with failures");
			$finish;
		end
	end
endmodule
`default_nettype wire
